>>> rtl/i2c_eeprom_master_macros.svh
// Assertion macros shared by the checker.
`ifndef I2C_EEPROM_MASTER_MACROS_SVH
`define I2C_EEPROM_MASTER_MACROS_SVH

// Clocked assertion, off while reset is asserted.
`define IEM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be seen.
`define IEM_ASSERT_NEVER(label, expr, msg) \
  `IEM_ASSERT(label, !(expr), msg)

`endif

>>> rtl/iem_pkg.sv
`timescale 1ns / 1ps

package iem_pkg;

  localparam int AddrW = 11;
  localparam int ByteW = 8;
  localparam int CntW  = 4;

  localparam logic [ByteW-1:0] CtrlBase   = 8'hA0;
  localparam logic [CntW-1:0]  ByteBits   = 4'd8;
  localparam logic [CntW-1:0]  RecClocks  = 4'd9;
  localparam logic             KindCmd    = 1'b0;

  typedef enum logic [1:0] {
    OP_WRITE     = 2'd0,
    OP_RAND_READ = 2'd1,
    OP_SEQ_READ  = 2'd2,
    OP_RECOVER   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    SYM_IDLE  = 2'd0,
    SYM_START = 2'd1,
    SYM_STOP  = 2'd2,
    SYM_BIT   = 2'd3
  } sym_e;

  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_START      = 4'd1,
    PH_CTRLW      = 4'd2,
    PH_ADDR       = 4'd3,
    PH_DATA       = 4'd4,
    PH_RSTART     = 4'd5,
    PH_CTRLR      = 4'd6,
    PH_READ       = 4'd7,
    PH_STOP       = 4'd8,
    PH_REC_START  = 4'd9,
    PH_REC_CLK    = 4'd10,
    PH_REC_START2 = 4'd11
  } phase_e;

  typedef struct packed {
    sym_e             bus_symbol;
    logic             sda_drive;
    logic             read_valid;
    logic [ByteW-1:0] read_data;
    logic [AddrW-1:0] read_address;
    logic             busy_res;
    logic             done_res;
    logic             nack_error;
    logic             cmd_rejected;
  } res_t;

  // Page bits a[10:8] land in control byte bits [3:1].
  function automatic logic [ByteW-1:0] control_byte(input logic [AddrW-1:0] a);
    control_byte = CtrlBase | {4'b0000, a[10:8], 1'b0};
  endfunction

endpackage

>>> rtl/iem_core.sv
`timescale 1ns / 1ps

module iem_core import iem_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic             kind_i,
  input  logic [1:0]       op_i,
  input  logic [AddrW-1:0] address_i,
  input  logic [AddrW-1:0] end_address_i,
  input  logic [ByteW-1:0] write_data_i,
  input  logic             sda_in_i,
  output res_t             res_o
);

  phase_e           phase_q, phase_d;
  logic [CntW-1:0]  bit_count_q, bit_count_d;
  logic [ByteW-1:0] shift_byte_q, shift_byte_d;
  logic [AddrW-1:0] cur_addr_q, cur_addr_d;
  logic [AddrW-1:0] last_addr_q, last_addr_d;
  logic [ByteW-1:0] data_byte_q, data_byte_d;
  op_e              active_op_q, active_op_d;
  logic             expect_ack_q, expect_ack_d;

  logic             send_en;
  phase_e           send_next;
  logic [ByteW-1:0] send_byte;
  logic [ByteW-1:0] rd_shift;
  op_e              op;

  assign op = op_e'(op_i);

  always_comb begin
    phase_d      = phase_q;
    bit_count_d  = bit_count_q;
    shift_byte_d = shift_byte_q;
    cur_addr_d   = cur_addr_q;
    last_addr_d  = last_addr_q;
    data_byte_d  = data_byte_q;
    active_op_d  = active_op_q;
    expect_ack_d = expect_ack_q;
    send_en      = 1'b0;
    send_next    = PH_IDLE;
    send_byte    = '0;
    rd_shift     = shift_byte_q;

    res_o            = '0;
    res_o.bus_symbol = SYM_IDLE;
    res_o.sda_drive  = 1'b1;

    if (kind_i == KindCmd) begin
      if (phase_q != PH_IDLE || (op == OP_SEQ_READ && address_i > end_address_i)) begin
        res_o.cmd_rejected = 1'b1;
      end else begin
        active_op_d  = op;
        cur_addr_d   = address_i;
        last_addr_d  = (op == OP_SEQ_READ) ? end_address_i : address_i;
        data_byte_d  = write_data_i;
        bit_count_d  = '0;
        shift_byte_d = '0;
        expect_ack_d = 1'b0;
        phase_d      = (op == OP_RECOVER) ? PH_REC_START : PH_START;
      end
    end else if (phase_q != PH_IDLE) begin
      expect_ack_d = 1'b0;
      if (expect_ack_q && sda_in_i) begin
        res_o.bus_symbol = SYM_STOP;
        res_o.done_res   = 1'b1;
        res_o.nack_error = 1'b1;
        phase_d          = PH_IDLE;
        bit_count_d      = '0;
      end else begin
        case (phase_q)
          PH_START: begin
            res_o.bus_symbol = SYM_START;
            shift_byte_d     = control_byte(cur_addr_q);
            bit_count_d      = '0;
            phase_d          = PH_CTRLW;
          end
          PH_CTRLW: begin
            send_en   = 1'b1;
            send_next = PH_ADDR;
            send_byte = cur_addr_q[ByteW-1:0];
          end
          PH_ADDR: begin
            send_en   = 1'b1;
            send_next = (active_op_q == OP_WRITE) ? PH_DATA : PH_RSTART;
            send_byte = (active_op_q == OP_WRITE) ? data_byte_q : '0;
          end
          PH_DATA: begin
            send_en   = 1'b1;
            send_next = PH_STOP;
          end
          PH_RSTART: begin
            res_o.bus_symbol = SYM_START;
            shift_byte_d     = control_byte(cur_addr_q) | 8'h01;
            bit_count_d      = '0;
            phase_d          = PH_CTRLR;
          end
          PH_CTRLR: begin
            send_en   = 1'b1;
            send_next = PH_READ;
          end
          PH_READ: begin
            if (bit_count_q != '0) begin
              rd_shift = {shift_byte_q[ByteW-2:0], sda_in_i};
            end
            shift_byte_d     = rd_shift;
            res_o.bus_symbol = SYM_BIT;
            if (bit_count_q < ByteBits) begin
              bit_count_d = bit_count_q + 1'b1;
            end else begin
              res_o.read_valid   = 1'b1;
              res_o.read_data    = rd_shift;
              res_o.read_address = cur_addr_q;
              bit_count_d        = '0;
              shift_byte_d       = '0;
              if (cur_addr_q < last_addr_q) begin
                res_o.sda_drive = 1'b0;
                cur_addr_d      = cur_addr_q + 1'b1;
              end else begin
                phase_d = PH_STOP;
              end
            end
          end
          PH_STOP: begin
            res_o.bus_symbol = SYM_STOP;
            res_o.done_res   = 1'b1;
            phase_d          = PH_IDLE;
            bit_count_d      = '0;
          end
          PH_REC_START: begin
            res_o.bus_symbol = SYM_START;
            bit_count_d      = '0;
            phase_d          = PH_REC_CLK;
          end
          PH_REC_CLK: begin
            res_o.bus_symbol = SYM_BIT;
            if (bit_count_q + 1'b1 >= RecClocks) begin
              bit_count_d = '0;
              phase_d     = PH_REC_START2;
            end else begin
              bit_count_d = bit_count_q + 1'b1;
            end
          end
          PH_REC_START2: begin
            res_o.bus_symbol = SYM_START;
            phase_d          = PH_STOP;
          end
          default: begin
            phase_d     = PH_IDLE;
            bit_count_d = '0;
          end
        endcase

        // byte shifter shared by all transmit phases, ack slot after bit 8
        if (send_en) begin
          res_o.bus_symbol = SYM_BIT;
          if (bit_count_q < ByteBits) begin
            res_o.sda_drive = shift_byte_q[ByteW-1];
            shift_byte_d    = {shift_byte_q[ByteW-2:0], 1'b0};
            bit_count_d     = bit_count_q + 1'b1;
          end else begin
            expect_ack_d = 1'b1;
            bit_count_d  = '0;
            shift_byte_d = send_byte;
            phase_d      = send_next;
          end
        end
      end
    end

    res_o.busy_res = (phase_d != PH_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      bit_count_q  <= '0;
      shift_byte_q <= '0;
      cur_addr_q   <= '0;
      last_addr_q  <= '0;
      data_byte_q  <= '0;
      active_op_q  <= OP_WRITE;
      expect_ack_q <= 1'b0;
    end else if (step_i) begin
      phase_q      <= phase_d;
      bit_count_q  <= bit_count_d;
      shift_byte_q <= shift_byte_d;
      cur_addr_q   <= cur_addr_d;
      last_addr_q  <= last_addr_d;
      data_byte_q  <= data_byte_d;
      active_op_q  <= active_op_d;
      expect_ack_q <= expect_ack_d;
    end
  end

endmodule

>>> rtl/i2c_eeprom_master.sv
`timescale 1ns / 1ps

// Bit-level I2C master for a 2 KiB EEPROM.
// Input channel (in_valid_i / in_stall_o): a word is either a command
// (kind 0: byte write, random read, sequential read, bus recovery) or a
// bus tick (kind 1) carrying the SDA level sampled in the previous slot.
// Output channel (out_valid_o / out_stall_i): exactly one result word per
// input word: the bus symbol to drive, SDA level, any received byte with
// its address, and busy/done/nack/reject flags.
// A word accepted into the input register is processed as it advances into
// the result register, and its result is offered from then on.
// Throughput: one word per cycle while the result is not stalled; the
// whole slot decision is one pass of the state machine between the input
// register and the result register.
// Stall: while the result is stalled, one more word is held in the input
// register, then in_stall_o rises. Nothing is dropped.
// Reset: both registers empty, the master idle with no transaction open.
module i2c_eeprom_master import iem_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             kind_i,
  input  logic [1:0]       op_i,
  input  logic [AddrW-1:0] address_i,
  input  logic [AddrW-1:0] end_address_i,
  input  logic [ByteW-1:0] write_data_i,
  input  logic             sda_in_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [1:0]       bus_symbol_o,
  output logic             sda_drive_o,
  output logic             read_valid_o,
  output logic [ByteW-1:0] read_data_o,
  output logic [AddrW-1:0] read_address_o,
  output logic             busy_res_o,
  output logic             done_res_o,
  output logic             nack_error_o,
  output logic             cmd_rejected_o
);

  logic             in_valid_q;
  logic             kind_q;
  logic [1:0]       op_q;
  logic [AddrW-1:0] address_q;
  logic [AddrW-1:0] end_address_q;
  logic [ByteW-1:0] write_data_q;
  logic             sda_in_q;
  logic             out_valid_q;
  res_t             res_d, res_q;
  logic             accept;
  logic             advance;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q        <= kind_i;
      op_q          <= op_i;
      address_q     <= address_i;
      end_address_q <= end_address_i;
      write_data_q  <= write_data_i;
      sda_in_q      <= sda_in_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  iem_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (advance),
    .kind_i        (kind_q),
    .op_i          (op_q),
    .address_i     (address_q),
    .end_address_i (end_address_q),
    .write_data_i  (write_data_q),
    .sda_in_i      (sda_in_q),
    .res_o         (res_d)
  );

  assign out_valid_o    = out_valid_q;
  assign bus_symbol_o   = res_q.bus_symbol;
  assign sda_drive_o    = res_q.sda_drive;
  assign read_valid_o   = res_q.read_valid;
  assign read_data_o    = res_q.read_data;
  assign read_address_o = res_q.read_address;
  assign busy_res_o     = res_q.busy_res;
  assign done_res_o     = res_q.done_res;
  assign nack_error_o   = res_q.nack_error;
  assign cmd_rejected_o = res_q.cmd_rejected;

endmodule

>>> rtl/iem_checker.sv
`timescale 1ns / 1ps
`include "i2c_eeprom_master_macros.svh"

module iem_checker import iem_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [1:0]       bus_symbol_o,
  input logic             sda_drive_o,
  input logic             read_valid_o,
  input logic [ByteW-1:0] read_data_o,
  input logic [AddrW-1:0] read_address_o,
  input logic             busy_res_o,
  input logic             done_res_o,
  input logic             nack_error_o,
  input logic             cmd_rejected_o
);

  `IEM_ASSERT(a_out_hold,
    out_valid_o && out_stall_i |=> out_valid_o && $stable(bus_symbol_o) &&
    $stable(sda_drive_o) && $stable(read_data_o) && $stable(read_address_o) &&
    $stable(busy_res_o),
    "stalled result word changed")
  `IEM_ASSERT_NEVER(a_read_on_bit,
    out_valid_o && read_valid_o && bus_symbol_o != SYM_BIT,
    "read byte outside a clocked bit")
  `IEM_ASSERT(a_done_stop,
    out_valid_o && done_res_o |-> bus_symbol_o == SYM_STOP && !busy_res_o,
    "done without stop or still busy")
  `IEM_ASSERT(a_nack_done, out_valid_o && nack_error_o |-> done_res_o, "nack without done")
  `IEM_ASSERT(a_reject_idle,
    out_valid_o && cmd_rejected_o |-> bus_symbol_o == SYM_IDLE && !read_valid_o,
    "rejected command drove the bus")

endmodule

bind i2c_eeprom_master iem_checker u_iem_checker (.*);
